### design/efsa_pkg.sv
`timescale 1ns / 1ps

package efsa_pkg;

	// Default sizing of the extent table and of a page number.
	localparam int MAX_EXTENTS_DEF = 64;
	localparam int PAGE_BITS_DEF   = 32;

	// Command codes carried in the request.
	localparam logic CMD_FREE  = 1'b0;
	localparam logic CMD_ALLOC = 1'b1;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOFIT   = 2'd1,
		ST_INVALID = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef struct packed {
		logic        cmd;
		logic [31:0] first_page;
		logic [31:0] end_page;
		logic [31:0] page_count;
	} efsa_req_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] got_start;
		logic [31:0] got_end;
		logic [6:0]  free_entries;
	} efsa_rsp_t;

	// What one cell of the sorted chain does at the end of the evaluation cycle.
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_LOAD_NEW,
		OP_TAKE_LEFT,
		OP_TAKE_RIGHT,
		OP_SET_LIMIT,
		OP_SET_BEGIN,
		OP_ADVANCE,
		OP_MERGE
	} cell_op_t;

	// Match results that one cell reports for the request under evaluation.
	typedef struct packed {
		logic overlap;
		logic left_match;
		logic right_match;
		logic above;
		logic fits;
		logic exact;
	} cell_flags_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_EVAL
	} fsm_state_t;

endpackage

### design/efsa_cell.sv
`timescale 1ns / 1ps

module efsa_cell #(
	parameter int PAGE_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  efsa_pkg::cell_op_t     op,
	input  logic [PAGE_BITS-1:0]   req_first,
	input  logic [PAGE_BITS-1:0]   req_end,
	input  logic [PAGE_BITS-1:0]   req_count,
	input  logic [PAGE_BITS-1:0]   left_begin,
	input  logic [PAGE_BITS-1:0]   left_limit,
	input  logic                   left_valid,
	input  logic [PAGE_BITS-1:0]   right_begin,
	input  logic [PAGE_BITS-1:0]   right_limit,
	input  logic                   right_valid,
	output logic [PAGE_BITS-1:0]   ext_begin,
	output logic [PAGE_BITS-1:0]   ext_limit,
	output logic                   ext_valid,
	output logic [PAGE_BITS-1:0]   ext_advanced,
	output efsa_pkg::cell_flags_t  flags
);
	import efsa_pkg::*;

	logic [PAGE_BITS-1:0] begin_q;
	logic [PAGE_BITS-1:0] limit_q;
	logic                 valid_q;
	logic [PAGE_BITS-1:0] span;

	assign ext_begin    = begin_q;
	assign ext_limit    = limit_q;
	assign ext_valid    = valid_q;
	assign ext_advanced = begin_q + req_count;
	assign span         = limit_q - begin_q;

	// An empty cell counts as lying above every start, which keeps the chain sorted.
	always_comb begin
		flags.overlap     = valid_q && (begin_q < req_end) && (req_first < limit_q);
		flags.left_match  = valid_q && (limit_q == req_first);
		flags.right_match = valid_q && (begin_q == req_end);
		flags.above       = !valid_q || (begin_q > req_first);
		flags.fits        = valid_q && (span >= req_count);
		flags.exact       = flags.fits && (ext_advanced == limit_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			unique case (op)
				OP_LOAD_NEW:   valid_q <= 1'b1;
				OP_TAKE_LEFT:  valid_q <= left_valid;
				OP_TAKE_RIGHT: valid_q <= right_valid;
				default:       valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD_NEW: begin
				begin_q <= req_first;
				limit_q <= req_end;
			end
			OP_TAKE_LEFT: begin
				begin_q <= left_begin;
				limit_q <= left_limit;
			end
			OP_TAKE_RIGHT: begin
				begin_q <= right_begin;
				limit_q <= right_limit;
			end
			OP_SET_LIMIT: limit_q <= req_end;
			OP_SET_BEGIN: begin_q <= req_first;
			OP_ADVANCE:   begin_q <= ext_advanced;
			OP_MERGE:     limit_q <= right_limit;
			default: begin
				begin_q <= begin_q;
				limit_q <= limit_q;
			end
		endcase
	end

endmodule

### design/extent_free_space_allocator.sv
`timescale 1ns / 1ps

// Channel   Ports                    Transaction
// --------  -----------------------  ------------------------------------------
// request   start, busy, request     taken at a rising edge with start high and
//                                    busy low
// result    done, result             valid for exactly one cycle while done is
//                                    high, taken at the edge that ends it
//
// Each transaction has the cycle that ends with the edge taking the request, then
// an evaluation cycle in which every cell compares its extent with the request
// in parallel; the chain shifts and the result register loads at its end.
// busy is high only in the evaluation cycle, so a new request is taken in the cycle
// in which done shows the previous result. Reset clears every valid bit and the
// entry count at once. The receiver cannot stall, so nothing holds results back.
module extent_free_space_allocator #(
	parameter int MAX_EXTENTS = efsa_pkg::MAX_EXTENTS_DEF,
	parameter int PAGE_BITS   = efsa_pkg::PAGE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  efsa_pkg::efsa_req_t request,
	output logic                done,
	output efsa_pkg::efsa_rsp_t result
);
	import efsa_pkg::*;

	localparam int CNT_W = $clog2(MAX_EXTENTS + 1);
	// Widths that cover both the internal and the port form of a value, so that
	// conversions work whether the internal form is narrower or wider.
	localparam int WIDE_W  = (PAGE_BITS > 32) ? PAGE_BITS : 32;
	localparam int CWIDE_W = (CNT_W > 7) ? CNT_W : 7;

	// The request as the cells see it, page values cut or zero-extended to the page width.
	typedef struct packed {
		logic                 cmd;
		logic [PAGE_BITS-1:0] first;
		logic [PAGE_BITS-1:0] last;
		logic [PAGE_BITS-1:0] count;
	} held_req_t;

	fsm_state_t state_q;
	fsm_state_t state_d;
	held_req_t  req_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	efsa_rsp_t  result_q;
	logic       done_q;
	logic       take;

	logic [WIDE_W-1:0] wide_first;
	logic [WIDE_W-1:0] wide_end;
	logic [WIDE_W-1:0] wide_count;

	logic [PAGE_BITS-1:0] cell_begin [MAX_EXTENTS];
	logic [PAGE_BITS-1:0] cell_limit [MAX_EXTENTS];
	logic                 cell_valid [MAX_EXTENTS];
	logic [PAGE_BITS-1:0] cell_adv   [MAX_EXTENTS];
	cell_flags_t          cell_flag  [MAX_EXTENTS];
	cell_op_t             cell_cmd   [MAX_EXTENTS];
	cell_op_t             plan       [MAX_EXTENTS];

	logic [MAX_EXTENTS-1:0] overlap_v;
	logic [MAX_EXTENTS-1:0] lmatch_v;
	logic [MAX_EXTENTS-1:0] rmatch_v;
	logic [MAX_EXTENTS-1:0] above_v;
	logic [MAX_EXTENTS-1:0] fit_v;
	logic [MAX_EXTENTS-1:0] exact_v;
	logic [MAX_EXTENTS-1:0] fit_first;
	logic [MAX_EXTENTS-1:0] fit_from;
	logic [MAX_EXTENTS-1:0] past_left;
	logic [MAX_EXTENTS-1:0] insert_at;
	logic [MAX_EXTENTS-1:0] past_insert;

	status_t              status_d;
	logic [PAGE_BITS-1:0] got_start_d;
	logic [PAGE_BITS-1:0] got_end_d;
	logic [WIDE_W-1:0]    wide_start;
	logic [WIDE_W-1:0]    wide_stop;
	logic [CWIDE_W-1:0]   wide_total;

	assign take = start && !busy;

	assign wide_first = WIDE_W'(request.first_page);
	assign wide_end   = WIDE_W'(request.end_page);
	assign wide_count = WIDE_W'(request.page_count);

	// Control: one idle state that takes requests and an evaluation state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: if (take) state_d = FSM_EVAL;
			FSM_EVAL: state_d = FSM_IDLE;
			default:  state_d = FSM_IDLE;
		endcase
	end

	always_comb begin
		unique case (state_q)
			FSM_EVAL: busy = 1'b1;
			default:  busy = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == FSM_EVAL);
			if (state_q == FSM_EVAL) begin
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_q.cmd   <= request.cmd;
			req_q.first <= wide_first[PAGE_BITS-1:0];
			req_q.last  <= wide_end[PAGE_BITS-1:0];
			req_q.count <= wide_count[PAGE_BITS-1:0];
		end
		if (state_q == FSM_EVAL) begin
			result_q <= {status_d, wide_start[31:0], wide_stop[31:0], wide_total[6:0]};
		end
	end

	// The chain of cells. Valid extents sit at the low end, sorted by start, so
	// the first fitting cell is the first fit by start and the neighbors of a
	// freed extent are adjacent cells. Shifts move one place toward either end.
	for (genvar i = 0; i < MAX_EXTENTS; i++) begin : g_cell
		logic [PAGE_BITS-1:0] lb;
		logic [PAGE_BITS-1:0] ll;
		logic                 lv;
		logic [PAGE_BITS-1:0] rb;
		logic [PAGE_BITS-1:0] rl;
		logic                 rv;

		if (i == 0) begin : g_first
			assign lb = '0;
			assign ll = '0;
			assign lv = 1'b0;
		end else begin : g_mid_l
			assign lb = cell_begin[i-1];
			assign ll = cell_limit[i-1];
			assign lv = cell_valid[i-1];
		end

		if (i == MAX_EXTENTS - 1) begin : g_last
			assign rb = '0;
			assign rl = '0;
			assign rv = 1'b0;
		end else begin : g_mid_r
			assign rb = cell_begin[i+1];
			assign rl = cell_limit[i+1];
			assign rv = cell_valid[i+1];
		end

		assign cell_cmd[i] = (state_q == FSM_EVAL) ? plan[i] : OP_HOLD;

		efsa_cell #(
			.PAGE_BITS(PAGE_BITS)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.op          (cell_cmd[i]),
			.req_first   (req_q.first),
			.req_end     (req_q.last),
			.req_count   (req_q.count),
			.left_begin  (lb),
			.left_limit  (ll),
			.left_valid  (lv),
			.right_begin (rb),
			.right_limit (rl),
			.right_valid (rv),
			.ext_begin   (cell_begin[i]),
			.ext_limit   (cell_limit[i]),
			.ext_valid   (cell_valid[i]),
			.ext_advanced(cell_adv[i]),
			.flags       (cell_flag[i])
		);

		assign overlap_v[i] = cell_flag[i].overlap;
		assign lmatch_v[i]  = cell_flag[i].left_match;
		assign rmatch_v[i]  = cell_flag[i].right_match;
		assign above_v[i]   = cell_flag[i].above;
		assign fit_v[i]     = cell_flag[i].fits;
		assign exact_v[i]   = cell_flag[i].exact;
	end

	// The lowest fitting cell, and the cells from it upward.
	assign fit_first = fit_v & (~fit_v + MAX_EXTENTS'(1));
	assign fit_from  = ~(fit_first - MAX_EXTENTS'(1));
	// At most one cell ends where the freed extent starts; these lie above it.
	assign past_left = ~(lmatch_v - MAX_EXTENTS'(1)) & ~lmatch_v;
	// The cells above the start form an upper run; the new entry goes at its foot.
	assign insert_at   = above_v & ~{above_v[MAX_EXTENTS-2:0], 1'b0};
	assign past_insert = above_v & ~insert_at;

	always_comb begin
		status_d    = ST_OK;
		count_d     = count_q;
		got_start_d = '0;
		got_end_d   = '0;
		for (int i = 0; i < MAX_EXTENTS; i++) begin
			plan[i] = OP_HOLD;
		end

		if (req_q.cmd == CMD_FREE) begin
			if ((req_q.last <= req_q.first) || (|overlap_v)) begin
				// A malformed or overlapping extent leaves the table alone.
				status_d = ST_INVALID;
			end else if ((|lmatch_v) && (|rmatch_v)) begin
				// Both neighbors join: the left one takes the right one's end,
				// and the chain closes the gap above it.
				for (int i = 0; i < MAX_EXTENTS; i++) begin
					if (lmatch_v[i]) plan[i] = OP_MERGE;
					else if (past_left[i]) plan[i] = OP_TAKE_RIGHT;
				end
				count_d = count_q - CNT_W'(1);
			end else if (|lmatch_v) begin
				for (int i = 0; i < MAX_EXTENTS; i++) begin
					if (lmatch_v[i]) plan[i] = OP_SET_LIMIT;
				end
			end else if (|rmatch_v) begin
				for (int i = 0; i < MAX_EXTENTS; i++) begin
					if (rmatch_v[i]) plan[i] = OP_SET_BEGIN;
				end
			end else if (count_q == CNT_W'(MAX_EXTENTS)) begin
				status_d = ST_FULL;
			end else begin
				// A fresh entry opens a slot in sorted order; the cells above move up.
				for (int i = 0; i < MAX_EXTENTS; i++) begin
					if (insert_at[i]) plan[i] = OP_LOAD_NEW;
					else if (past_insert[i]) plan[i] = OP_TAKE_LEFT;
				end
				count_d = count_q + CNT_W'(1);
			end
		end else begin
			if (req_q.count == '0) begin
				status_d = ST_INVALID;
			end else if (!(|fit_v)) begin
				status_d = ST_NOFIT;
			end else begin
				for (int i = 0; i < MAX_EXTENTS; i++) begin
					if (fit_first[i]) begin
						got_start_d = got_start_d | cell_begin[i];
						got_end_d   = got_end_d | cell_adv[i];
					end
				end
				if (|(fit_first & exact_v)) begin
					// An exact fit empties its cell; the chain closes over it.
					for (int i = 0; i < MAX_EXTENTS; i++) begin
						if (fit_from[i]) plan[i] = OP_TAKE_RIGHT;
					end
					count_d = count_q - CNT_W'(1);
				end else begin
					for (int i = 0; i < MAX_EXTENTS; i++) begin
						if (fit_first[i]) plan[i] = OP_ADVANCE;
					end
				end
			end
		end
	end

	assign wide_start = WIDE_W'(got_start_d);
	assign wide_stop  = WIDE_W'(got_end_d);
	assign wide_total = CWIDE_W'(count_d);

	assign done   = done_q;
	assign result = result_q;

endmodule
